// ===== sv/bf_pkg.sv =====
package bf_pkg;

    // Field widths fixed by the item format.
    localparam int FUNC_W  = 3;
    localparam int BIDX_W  = 11;
    localparam int KIND_W  = 2;
    localparam int FBITS_W = 15;
    localparam int HCNT_W  = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 15;

    // Hash constants.
    localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    // Function codes of an input item.
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_TEST  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd2;
    localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_READ  = 3'd4;

    // Result kinds.
    localparam logic [KIND_W-1:0] RK_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] RK_TEST  = 2'd1;
    localparam logic [KIND_W-1:0] RK_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] RK_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_BITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 1'd1;

    // Back-end operation codes.
    typedef enum logic [2:0] {
        OP_ADD,
        OP_TEST,
        OP_CLEAR,
        OP_LOAD,
        OP_READ
    } op_t;

    // One FNV-1a byte step.
    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        begin
            x = h ^ {24'd0, b};
            fnv_step = x * FNV_PRIME;
        end
    endfunction

    // Seeded accumulator for hash s: FNV-1a over the four bytes of s.
    function automatic logic [31:0] fnv_seed(input logic [31:0] s);
        logic [31:0] h;
        begin
            h = FNV_BASIS;
            for (int k = 0; k < 4; k++)
            begin
                h = fnv_step(h, s[8*k +: 8]);
            end
            fnv_seed = h;
        end
    endfunction

endpackage

// ===== sv/bf_if.sv =====
interface bf_in_if;
    import bf_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [7:0]        key_byte;
    logic              key_last;
    logic [BIDX_W-1:0] byte_index;
    logic [7:0]        load_byte;
    modport source (output valid, func, key_byte, key_last, byte_index, load_byte,
                    input ready);
    modport sink   (input valid, func, key_byte, key_last, byte_index, load_byte,
                    output ready);
endinterface

interface bf_out_if;
    import bf_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic              hit;
    logic [7:0]        read_byte;
    logic              read_error;
    modport source (output valid, result_kind, hit, read_byte, read_error, input ready);
    modport sink   (input valid, result_kind, hit, read_byte, read_error, output ready);
endinterface

interface bf_cfg_if;
    import bf_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/bf_ram.sv =====
module bf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bf_mod.sv =====
// Sequential remainder: one quotient bit per cycle, restoring division.
module bf_mod #(
    parameter int DW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] remainder
);

    logic [5:0]    cnt_reg, cnt_next;
    logic [31:0]   num_reg, num_next;
    logic [DW:0]   rem_reg, rem_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW+1:0] trial;

    assign trial     = {rem_reg, num_reg[31]} - {2'b00, divisor};
    assign done      = done_reg;
    assign remainder = rem_reg[DW-1:0];

    // Shift in one dividend bit per cycle and subtract when it fits.
    always_comb
    begin
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = 6'd32;
            num_next  = dividend;
            rem_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[30:0], 1'b0};
            if (!trial[DW+1])
            begin
                rem_next = trial[DW:0];
            end
            else
            begin
                rem_next = {rem_reg[DW-1:0], num_reg[31]};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

endmodule

// ===== sv/bf_front.sv =====
// Front part: takes input items, runs the hash accumulators, and hands
// finished operations to the queue.
module bf_front #(
    parameter int MAX_HASHES = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    bf_in_if.sink                    in_ch,
    output logic                     q_push,
    input  logic                     q_full,
    output bf_pkg::op_t              q_op,
    output logic [bf_pkg::BIDX_W-1:0] q_idx,
    output logic [7:0]               q_byte,
    output logic [MAX_HASHES*32-1:0] q_hashes
);
    import bf_pkg::*;

    logic [31:0] acc_reg [MAX_HASHES];
    logic [31:0] acc_next [MAX_HASHES];
    logic        is_key;
    logic        take;

    assign in_ch.ready = !q_full;
    assign take        = in_ch.valid && !q_full;
    assign is_key      = (in_ch.func == FN_ADD) || (in_ch.func == FN_TEST);

    // Update every accumulator with the key byte; reseed after the last byte.
    always_comb
    begin
        for (int s = 0; s < MAX_HASHES; s++)
        begin
            acc_next[s] = fnv_step(acc_reg[s], in_ch.key_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_HASHES; s++)
            begin
                acc_reg[s] <= fnv_seed(32'(s));
            end
        end
        else if (take && is_key)
        begin
            for (int s = 0; s < MAX_HASHES; s++)
            begin
                acc_reg[s] <= in_ch.key_last ? fnv_seed(32'(s)) : acc_next[s];
            end
        end
    end

    // Classify the item and push the operations that need the back part.
    always_comb
    begin
        q_push = 1'b0;
        q_op   = OP_ADD;
        case (in_ch.func)
            FN_ADD:
            begin
                q_op   = OP_ADD;
                q_push = take && in_ch.key_last;
            end
            FN_TEST:
            begin
                q_op   = OP_TEST;
                q_push = take && in_ch.key_last;
            end
            FN_CLEAR:
            begin
                q_op   = OP_CLEAR;
                q_push = take;
            end
            FN_LOAD:
            begin
                q_op   = OP_LOAD;
                q_push = take;
            end
            FN_READ:
            begin
                q_op   = OP_READ;
                q_push = take;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
        q_idx  = in_ch.byte_index;
        q_byte = in_ch.load_byte;
        for (int s = 0; s < MAX_HASHES; s++)
        begin
            q_hashes[s*32 +: 32] = acc_next[s];
        end
    end

endmodule

// ===== sv/bf_queue.sv =====
// Two-entry queue between front and back.
module bf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             nempty,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ent_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;

    assign full   = (cnt_reg == 2'd2);
    assign nempty = (cnt_reg != 2'd0);
    assign rdata  = ent_reg[rp_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= !wp_reg;
            end
            if (pop)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= wdata;
        end
    end

endmodule

// ===== sv/bf_back.sv =====
// Back part: reduces hashes to bit positions, touches the filter memory and
// produces results. One operation at a time. After reset it sweeps the
// filter memory to zero before it takes the first queued item.
module bf_back #(
    parameter int MAX_FILTER_BITS = 16384,
    parameter int MAX_HASHES      = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_nempty,
    output logic                      q_pop,
    input  bf_pkg::op_t               q_op,
    input  logic [bf_pkg::BIDX_W-1:0] q_idx,
    input  logic [7:0]                q_byte,
    input  logic [MAX_HASHES*32-1:0]  q_hashes,
    input  logic [$clog2(MAX_FILTER_BITS+1)-1:0] nbits,
    input  logic [$clog2(MAX_HASHES+1)-1:0]      nhash,
    bf_out_if.source                  out_ch
);
    import bf_pkg::*;

    localparam int NBYTES = (MAX_FILTER_BITS + 7) / 8;
    localparam int AW     = (NBYTES > 1) ? $clog2(NBYTES) : 1;
    localparam int PW     = $clog2(MAX_FILTER_BITS + 1);
    localparam int HW     = $clog2(MAX_HASHES + 1);
    localparam int SW     = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int CW     = PW + BIDX_W + 4;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MOD, ST_MODW, ST_RD, ST_RDW, ST_RMW,
        ST_CLR, ST_LRD, ST_LRDW, ST_LWR, ST_RRD, ST_RRDW, ST_OUT
    } state_t;

    state_t                 state_reg;
    op_t                    op_reg;
    logic [MAX_HASHES*32-1:0] hash_reg;
    logic [BIDX_W-1:0]      idx_reg;
    logic [7:0]             lbyte_reg;
    logic [SW-1:0]          sel_reg;
    logic [HW-1:0]          cnt_reg;
    logic [PW-1:0]          pos_reg;
    logic [AW-1:0]          clr_reg;
    logic                   boot_reg;
    logic                   hit_reg;
    logic                   ovalid_reg;
    logic [KIND_W-1:0]      okind_reg;
    logic                   ohit_reg;
    logic [7:0]             obyte_reg;
    logic                   oerr_reg;

    logic             m_start, m_done;
    logic [PW-1:0]    m_rem;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [7:0]       wdata, rdata;
    logic             in_range;
    logic [BIDX_W+2:0] idx_bits;

    bf_mod #(.DW(PW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (m_start),
        .dividend  (hash_reg[sel_reg*32 +: 32]),
        .divisor   (nbits),
        .done      (m_done),
        .remainder (m_rem)
    );

    bf_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Byte index against the effective filter size in bytes.
    assign idx_bits = {idx_reg, 3'b000};
    assign in_range = (CW'(idx_bits) + CW'(8)) <= CW'(nbits);

    assign m_start = (state_reg == ST_MOD);
    assign q_pop   = (state_reg == ST_IDLE) && q_nempty;

    // Memory port selection.
    always_comb
    begin
        we    = 1'b0;
        waddr = AW'(pos_reg >> 3);
        wdata = rdata | 8'(1 << pos_reg[2:0]);
        raddr = AW'(pos_reg >> 3);
        case (state_reg)
            ST_RMW:
            begin
                we = (op_reg == OP_ADD);
            end
            ST_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = 8'd0;
            end
            ST_LWR:
            begin
                we    = in_range && (32'(idx_reg) < NBYTES);
                waddr = AW'(idx_reg);
                wdata = lbyte_reg;
            end
            ST_LRD, ST_LRDW, ST_RRD, ST_RRDW, ST_OUT:
            begin
                raddr = AW'(idx_reg);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    assign out_ch.valid       = ovalid_reg;
    assign out_ch.result_kind = okind_reg;
    assign out_ch.hit         = ohit_reg;
    assign out_ch.read_byte   = obyte_reg;
    assign out_ch.read_error  = oerr_reg;

    // Sequencer and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            boot_reg   <= 1'b1;
            ovalid_reg <= 1'b0;
            op_reg     <= OP_ADD;
            sel_reg    <= '0;
            cnt_reg    <= '0;
            clr_reg    <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_nempty)
                    begin
                        op_reg    <= q_op;
                        hash_reg  <= q_hashes;
                        idx_reg   <= q_idx;
                        lbyte_reg <= q_byte;
                        sel_reg   <= '0;
                        cnt_reg   <= nhash;
                        clr_reg   <= '0;
                        hit_reg   <= 1'b1;
                        unique case (q_op)
                            OP_ADD, OP_TEST: state_reg <= ST_MOD;
                            OP_CLEAR:        state_reg <= ST_CLR;
                            OP_LOAD:         state_reg <= ST_LWR;
                            OP_READ:         state_reg <= ST_RRD;
                            default:         state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_MOD:
                begin
                    state_reg <= ST_MODW;
                end
                ST_MODW:
                begin
                    if (m_done)
                    begin
                        pos_reg   <= m_rem;
                        state_reg <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_RDW;
                end
                ST_RDW:
                begin
                    state_reg <= ST_RMW;
                end
                ST_RMW:
                begin
                    if (!rdata[pos_reg[2:0]])
                    begin
                        hit_reg <= 1'b0;
                    end
                    if (cnt_reg == HW'(1))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg - HW'(1);
                        sel_reg   <= sel_reg + SW'(1);
                        state_reg <= ST_MOD;
                    end
                end
                ST_CLR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (32'(clr_reg) == (1 << AW) - 1)
                    begin
                        // The sweep after reset gives no result.
                        boot_reg  <= 1'b0;
                        state_reg <= boot_reg ? ST_IDLE : ST_OUT;
                    end
                end
                ST_LWR:
                begin
                    state_reg <= ST_IDLE;
                end
                ST_RRD:
                begin
                    state_reg <= ST_RRDW;
                end
                ST_RRDW:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ovalid_reg || out_ch.ready)
                    begin
                        ovalid_reg <= 1'b1;
                        okind_reg  <= (op_reg == OP_ADD)   ? RK_ADD :
                                      (op_reg == OP_TEST)  ? RK_TEST :
                                      (op_reg == OP_CLEAR) ? RK_CLEAR : RK_READ;
                        ohit_reg   <= (op_reg == OP_TEST) && hit_reg;
                        obyte_reg  <= (op_reg == OP_READ && in_range) ? rdata : 8'd0;
                        oerr_reg   <= (op_reg == OP_READ) && !in_range;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (ovalid_reg && out_ch.ready &&
                !(state_reg == ST_OUT))
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== sv/bloom_filter_fnv1a.sv =====
// Channel   Direction  Payload
// in_ch     sink       func, key_byte, key_last, byte_index, load_byte
// out_ch    source     result_kind, hit, read_byte, read_error
// cfg_ch    sink       index, data
//
// A last key byte costs, per hash, a pass of the bit-serial remainder unit
// and a filter memory read-modify-write. Clear sweeps all filter bytes, one
// per cycle. Reset is asynchronous; after it the back part sweeps the filter
// memory to zero before it serves the queue. A two-entry queue lets the front
// keep accepting key bytes while the back is busy or the output stalls, until
// the queue is full.
module bloom_filter_fnv1a #(
    parameter int MAX_FILTER_BITS = 16384,
    parameter int MAX_HASHES      = 8
) (
    input logic    clk,
    input logic    rst_n,
    bf_in_if.sink  in_ch,
    bf_out_if.source out_ch,
    bf_cfg_if.sink cfg_ch
);
    import bf_pkg::*;

    localparam int PW = $clog2(MAX_FILTER_BITS + 1);
    localparam int HW = $clog2(MAX_HASHES + 1);
    localparam int QW = 3 + BIDX_W + 8 + MAX_HASHES * 32;

    logic [FBITS_W-1:0] fbits_reg;
    logic [HCNT_W-1:0]  hcnt_reg;
    logic [PW-1:0]      nbits;
    logic [HW-1:0]      nhash;

    logic                     f_push, q_full, q_pop, q_nempty;
    op_t                      f_op, b_op;
    logic [BIDX_W-1:0]        f_idx, b_idx;
    logic [7:0]               f_byte, b_byte;
    logic [MAX_HASHES*32-1:0] f_hash, b_hash;
    logic [QW-1:0]            q_rdata;

    // Configuration registers.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbits_reg <= FBITS_W'(16384);
            hcnt_reg  <= HCNT_W'(3);
        end
        else if (cfg_ch.valid)
        begin
            if (cfg_ch.index == REG_FILTER_BITS)
            begin
                fbits_reg <= cfg_ch.data;
            end
            else if (cfg_ch.index == REG_HASH_COUNT)
            begin
                hcnt_reg <= cfg_ch.data[HCNT_W-1:0];
            end
        end
    end

    // Clamp to the effective ranges.
    always_comb
    begin
        if (32'(fbits_reg) < 8)
        begin
            nbits = PW'(8);
        end
        else if (32'(fbits_reg) > MAX_FILTER_BITS)
        begin
            nbits = PW'(MAX_FILTER_BITS);
        end
        else
        begin
            nbits = PW'(fbits_reg);
        end
        if (hcnt_reg == '0)
        begin
            nhash = HW'(1);
        end
        else if (32'(hcnt_reg) > MAX_HASHES)
        begin
            nhash = HW'(MAX_HASHES);
        end
        else
        begin
            nhash = HW'(hcnt_reg);
        end
    end

    bf_front #(.MAX_HASHES(MAX_HASHES)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .q_push   (f_push),
        .q_full   (q_full),
        .q_op     (f_op),
        .q_idx    (f_idx),
        .q_byte   (f_byte),
        .q_hashes (f_hash)
    );

    bf_queue #(.WIDTH(QW)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (f_push),
        .wdata  ({3'(f_op), f_idx, f_byte, f_hash}),
        .full   (q_full),
        .pop    (q_pop),
        .nempty (q_nempty),
        .rdata  (q_rdata)
    );

    assign b_op   = op_t'(q_rdata[QW-1 -: 3]);
    assign b_idx  = q_rdata[QW-4 -: BIDX_W];
    assign b_byte = q_rdata[MAX_HASHES*32 +: 8];
    assign b_hash = q_rdata[MAX_HASHES*32-1:0];

    bf_back #(.MAX_FILTER_BITS(MAX_FILTER_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_nempty (q_nempty),
        .q_pop    (q_pop),
        .q_op     (b_op),
        .q_idx    (b_idx),
        .q_byte   (b_byte),
        .q_hashes (b_hash),
        .nbits    (nbits),
        .nhash    (nhash),
        .out_ch   (out_ch)
    );

endmodule

// ===== sv/bf_checker.sv =====
module bf_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [bf_pkg::KIND_W-1:0] out_kind,
    input logic                      out_hit,
    input logic [7:0]                out_byte,
    input logic                      out_err
);
    import bf_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind))
        else $error("result changed while stalled");

    // Only a test answer carries a hit.
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_hit |-> out_kind == RK_TEST)
        else $error("hit outside test answer");

    // Read fields are zero outside read data.
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind != RK_READ |-> out_byte == 8'd0 && !out_err)
        else $error("read fields set outside read data");

    // An error read returns zero.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_byte == 8'd0)
        else $error("error read with data");

endmodule

bind bloom_filter_fnv1a bf_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.result_kind),
    .out_hit   (out_ch.hit),
    .out_byte  (out_ch.read_byte),
    .out_err   (out_ch.read_error)
);

// ===== verif/bloom_filter_fnv1a_tb.sv =====
`timescale 1ns / 1ps

module bloom_filter_fnv1a_tb;
    import bf_pkg::*;

    localparam int FILTER_MAX = 16384;
    localparam int HASH_MAX   = 8;
    localparam int SETTLE_CYCLES = 400;
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [7:0]        key_byte;
        logic              key_last;
        logic [BIDX_W-1:0] byte_index;
        logic [7:0]        load_byte;
    } bf_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              hit;
        logic [7:0]        rbyte;
        logic              rerr;
    } bf_answer_t;

    logic clk;
    logic rst_n;

    bf_in_if  in_ch ();
    bf_out_if out_ch ();
    bf_cfg_if cfg_ch ();

    bloom_filter_fnv1a u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // Shadow copy of the filter, hash state and registers.
    logic [FILTER_MAX-1:0] shadow_bits;
    logic [31:0]           shadow_acc [HASH_MAX];
    logic [FBITS_W-1:0]    shadow_fbits;
    logic [HCNT_W-1:0]     shadow_hcnt;

    bf_item_t   pending_items [$];
    bf_answer_t expected_answers [$];
    int         pushed_cnt;
    int         accepted_cnt;
    int         mismatch_cnt;
    bit         no_idle;
    int         added_keys [$];
    int         key_serial;

    // Clock.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        begin
            x = h ^ {24'd0, b};
            return x * 32'h01000193;
        end
    endfunction

    function automatic logic [31:0] seeded_hash(input int s);
        logic [31:0] h;
        logic [31:0] sv;
        begin
            h = 32'h811C9DC5;
            sv = s;
            for (int k = 0; k < 4; k++)
            begin
                h = fnv_mix(h, sv[8*k +: 8]);
            end
            return h;
        end
    endfunction

    function automatic int live_bits();
        begin
            if (shadow_fbits < 8)
                return 8;
            if (shadow_fbits > FILTER_MAX)
                return FILTER_MAX;
            return shadow_fbits;
        end
    endfunction

    function automatic int live_hashes();
        begin
            if (shadow_hcnt == 0)
                return 1;
            if (shadow_hcnt > HASH_MAX)
                return HASH_MAX;
            return shadow_hcnt;
        end
    endfunction

    // Apply one accepted item to the shadow state and queue its answer, if any.
    task automatic predict_item(input bf_item_t it);
        bf_answer_t ans;
        int nb;
        int pos;
        begin
            ans = '0;
            nb = live_bits();
            if (it.func == FN_ADD || it.func == FN_TEST)
            begin
                for (int s = 0; s < HASH_MAX; s++)
                begin
                    shadow_acc[s] = fnv_mix(shadow_acc[s], it.key_byte);
                end
                if (it.key_last)
                begin
                    ans.hit = (it.func == FN_TEST);
                    for (int s = 0; s < live_hashes(); s++)
                    begin
                        pos = shadow_acc[s] % nb;
                        if (it.func == FN_ADD)
                            shadow_bits[pos] = 1'b1;
                        else if (!shadow_bits[pos])
                            ans.hit = 1'b0;
                    end
                    for (int s = 0; s < HASH_MAX; s++)
                    begin
                        shadow_acc[s] = seeded_hash(s);
                    end
                    ans.kind = (it.func == FN_ADD) ? RK_ADD : RK_TEST;
                    expected_answers.push_back(ans);
                end
            end
            else if (it.func == FN_CLEAR)
            begin
                shadow_bits = '0;
                ans.kind = RK_CLEAR;
                expected_answers.push_back(ans);
            end
            else if (it.func == FN_LOAD)
            begin
                if (it.byte_index < nb / 8)
                    shadow_bits[it.byte_index*8 +: 8] = it.load_byte;
            end
            else if (it.func == FN_READ)
            begin
                ans.kind = RK_READ;
                if (it.byte_index < nb / 8)
                    ans.rbyte = shadow_bits[it.byte_index*8 +: 8];
                else
                    ans.rerr = 1'b1;
                expected_answers.push_back(ans);
            end
        end
    endtask

    // Input driver with per-item gaps; predicts each item as it is accepted.
    int send_gap;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_item({in_ch.func, in_ch.key_byte, in_ch.key_last,
                              in_ch.byte_index, in_ch.load_byte});
                accepted_cnt++;
            end
            if (!(in_ch.valid && !in_ch.ready))
            begin
                if (send_gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_items.size() > 0)
                begin
                    bf_item_t nx;
                    nx = pending_items.pop_front();
                    in_ch.func       <= nx.func;
                    in_ch.key_byte   <= nx.key_byte;
                    in_ch.key_last   <= nx.key_last;
                    in_ch.byte_index <= nx.byte_index;
                    in_ch.load_byte  <= nx.load_byte;
                    in_ch.valid      <= 1'b1;
                    send_gap = no_idle ? 0 : $urandom_range(0, 10);
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with per-item stalls.
    int recv_stall;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                bf_answer_t want;
                if (expected_answers.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result kind=%0d hit=%0d byte=%0h err=%0d",
                                 out_ch.result_kind, out_ch.hit, out_ch.read_byte,
                                 out_ch.read_error);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (out_ch.result_kind !== want.kind || out_ch.hit !== want.hit ||
                        out_ch.read_byte !== want.rbyte || out_ch.read_error !== want.rerr)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: expected kind=%0d hit=%0d byte=%0h err=%0d, got kind=%0d hit=%0d byte=%0h err=%0d",
                                     want.kind, want.hit, want.rbyte, want.rerr,
                                     out_ch.result_kind, out_ch.hit, out_ch.read_byte,
                                     out_ch.read_error);
                    end
                end
                recv_stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (recv_stall > 0)
            begin
                out_ch.ready <= 1'b0;
                recv_stall--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic push_item(input logic [FUNC_W-1:0] f, input logic [7:0] kb,
                             input logic kl, input logic [BIDX_W-1:0] bi,
                             input logic [7:0] lb);
        begin
            pending_items.push_back({f, kb, kl, bi, lb});
            pushed_cnt++;
        end
    endtask

    // Keys are derived from an id so that a test can repeat an earlier add.
    function automatic logic [7:0] key_content(input int id, input int k);
        logic [31:0] h;
        begin
            h = fnv_mix(seeded_hash(id), k[7:0]);
            return h[15:8];
        end
    endfunction

    task automatic push_key(input int id, input logic [FUNC_W-1:0] final_fn);
        int len;
        begin
            len = 1 + (id % 6);
            for (int k = 0; k < len; k++)
            begin
                if (k == len - 1)
                    push_item(final_fn, key_content(id, k), 1'b1,
                              BIDX_W'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
                else
                    push_item($urandom_range(0, 1) ? FN_TEST : FN_ADD, key_content(id, k),
                              1'b0, BIDX_W'($urandom_range(0, 2047)),
                              8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        begin
            cfg_ch.index <= idx;
            cfg_ch.data  <= val;
            cfg_ch.valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ch.ready);
            if (idx == REG_FILTER_BITS)
                shadow_fbits = val;
            else
                shadow_hcnt = val[HCNT_W-1:0];
        end
    endtask

    // Hold off until every item is in and every answer is out.
    task automatic drain();
        begin
            wait (accepted_cnt == pushed_cnt && expected_answers.size() == 0);
            repeat (SETTLE_CYCLES) @(posedge clk);
        end
    endtask

    task automatic random_phase(input int n_items);
        int start;
        int r;
        int idx_lim;
        begin
            start = pushed_cnt;
            idx_lim = live_bits() / 8;
            while (pushed_cnt - start < n_items)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    added_keys.push_back(key_serial);
                    push_key(key_serial, FN_ADD);
                    key_serial++;
                end
                else if (r < 55 && added_keys.size() > 0)
                begin
                    push_key(added_keys[$urandom_range(0, added_keys.size() - 1)], FN_TEST);
                end
                else if (r < 68)
                begin
                    push_key(key_serial, FN_TEST);
                    key_serial++;
                end
                else if (r < 78)
                begin
                    push_item(FN_LOAD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              BIDX_W'($urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, idx_lim - 1)),
                              8'($urandom_range(0, 255)));
                end
                else if (r < 92)
                begin
                    push_item(FN_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              BIDX_W'($urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                           : $urandom_range(0, idx_lim - 1)),
                              8'($urandom_range(0, 255)));
                end
                else if (r < 99)
                begin
                    push_item(FN_SPARE_FIRST + FUNC_W'($urandom_range(0, 2)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              BIDX_W'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
                end
                else
                begin
                    push_item(FN_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              BIDX_W'($urandom_range(0, 2047)), 8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Stimulus and phase sequencing.
    initial
    begin
        logic [CFG_DAT_W-1:0] fbits_set [9];
        logic [CFG_DAT_W-1:0] hcnt_set [9];
        fbits_set = '{15'd8, 15'd16384, 15'd0, 15'd32767, 15'd64, 15'd1000, 15'd257,
                      15'd7, 15'd16384};
        hcnt_set  = '{15'd1, 15'd8, 15'd0, 15'd15, 15'd2, 15'd5, 15'd4, 15'd9, 15'd3};

        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = FN_ADD;
        in_ch.key_byte = '0;
        in_ch.key_last = 1'b0;
        in_ch.byte_index = '0;
        in_ch.load_byte = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_FILTER_BITS;
        cfg_ch.data = '0;
        shadow_bits = '0;
        shadow_fbits = 15'd16384;
        shadow_hcnt = 4'd3;
        for (int s = 0; s < HASH_MAX; s++)
        begin
            shadow_acc[s] = seeded_hash(s);
        end
        pushed_cnt = 0;
        accepted_cnt = 0;
        mismatch_cnt = 0;
        send_gap = 0;
        recv_stall = 0;
        no_idle = 1'b0;
        key_serial = 100;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings; the filter memory starts with a clear.
        push_item(FN_CLEAR, 8'h00, 1'b0, 11'd0, 8'h00);
        push_item(FN_ADD, 8'h00, 1'b1, 11'h7FF, 8'hFF);
        push_item(FN_TEST, 8'h00, 1'b1, 11'd0, 8'h00);
        push_item(FN_TEST, 8'hFF, 1'b1, 11'd0, 8'h00);
        push_item(FN_TEST, 8'hA5, 1'b0, 11'd0, 8'h00);
        push_item(FN_ADD, 8'h5A, 1'b0, 11'd0, 8'h00);
        push_item(FN_ADD, 8'hFF, 1'b1, 11'd0, 8'h00);
        push_item(FN_ADD, 8'hA5, 1'b0, 11'd0, 8'h00);
        push_item(FN_TEST, 8'h5A, 1'b0, 11'd0, 8'h00);
        push_item(FN_TEST, 8'hFF, 1'b1, 11'd0, 8'h00);
        push_item(FN_LOAD, 8'h00, 1'b0, 11'd0, 8'hFF);
        push_item(FN_LOAD, 8'hFF, 1'b1, 11'h7FF, 8'hA5);
        push_item(FN_READ, 8'h00, 1'b0, 11'd0, 8'h00);
        push_item(FN_READ, 8'hFF, 1'b1, 11'h7FF, 8'hFF);
        push_item(FN_READ, 8'h00, 1'b0, 11'd1, 8'h00);
        push_item(FN_SPARE_FIRST, 8'hFF, 1'b1, 11'h7FF, 8'hFF);
        push_item(FN_SPARE_FIRST + 3'd1, 8'h00, 1'b0, 11'd0, 8'h00);
        push_item(FN_SPARE_FIRST + 3'd2, 8'h12, 1'b1, 11'd5, 8'h34);
        // A clear and a load in the middle of a key leave the key intact.
        push_item(FN_ADD, 8'h11, 1'b0, 11'd0, 8'h00);
        push_item(FN_CLEAR, 8'h00, 1'b0, 11'd0, 8'h00);
        push_item(FN_LOAD, 8'h00, 1'b0, 11'd3, 8'h3C);
        push_item(FN_ADD, 8'h22, 1'b1, 11'd0, 8'h00);
        push_item(FN_TEST, 8'h11, 1'b0, 11'd0, 8'h00);
        push_item(FN_TEST, 8'h22, 1'b1, 11'd0, 8'h00);
        push_item(FN_READ, 8'h00, 1'b0, 11'd3, 8'h00);
        drain();

        // Random phases over a range of register settings.
        for (int p = 0; p < 9; p++)
        begin
            cfg_write(REG_FILTER_BITS, fbits_set[p]);
            cfg_write(REG_HASH_COUNT, hcnt_set[p]);
            cfg_ch.valid <= 1'b0;
            added_keys.delete();
            no_idle = (p % 3 == 1);
            random_phase(170);
            drain();
        end

        if (mismatch_cnt == 0 && expected_answers.size() == 0)
        begin
            $display("bloom_filter_fnv1a_tb OK");
        end
        else
        begin
            $display("bloom_filter_fnv1a_tb NOT OK");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #30ms;
        $display("bloom_filter_fnv1a_tb NOT OK");
        $finish;
    end

endmodule
